// File: rtl/iprm_pkg.sv
// Shared types and constants for the ICMP probe reply matcher.
package iprm_pkg;

  // Parse progress through the ICMP part of a packet
  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_ECHO     = 2'd1,
    KIND_TE_WAIT  = 2'd2,
    KIND_TE_FOUND = 2'd3
  } kind_t;

  localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;
  localparam logic [7:0] ICMP_TTL_EXCEEDED = 8'd11;

  // Byte positions of the outer IPv4 source address
  localparam logic [15:0] SRC_FIRST_BYTE = 16'd12;
  localparam logic [15:0] SRC_LAST_BYTE  = 16'd15;
  // Minimum length for a packet that carries the whole source address
  localparam logic [15:0] MIN_PACKET_BYTES = 16'd16;
  // Quoted inner header starts this far into the ICMP header
  localparam logic [15:0] INNER_HDR_OFFSET = 16'd8;

  // Register indexes on the configuration port (paddr[3:2])
  localparam logic [1:0] REG_EXPECTED_ID = 2'd0;
  localparam logic [1:0] REG_CURRENT_TTL = 2'd1;
  localparam logic [1:0] REG_DEST_ADDR   = 2'd2;

  typedef struct packed {
    logic [15:0] expected_id;
    logic [7:0]  current_ttl;
    logic [31:0] destination_addr;
  } cfg_t;

  // Per-packet summary handed from the parser to the result stage
  typedef struct packed {
    logic        well_formed;
    logic        reply_kind;
    logic [15:0] probe_id;
    logic [15:0] probe_seq;
    logic [31:0] source_addr;
  } summary_t;

endpackage

// File: rtl/iprm_cfg_regs.sv
// Configuration register file with APB-style access.
module iprm_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output iprm_pkg::cfg_t     cfg
);

  logic [15:0] expected_id;
  logic [7:0]  current_ttl;
  logic [31:0] destination_addr;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id      <= 16'd0;
      current_ttl      <= 8'd1;
      destination_addr <= 32'd0;
    end else if (wr_en) begin
      case (paddr[3:2])
        iprm_pkg::REG_EXPECTED_ID: expected_id      <= pwdata[15:0];
        iprm_pkg::REG_CURRENT_TTL: current_ttl      <= pwdata[7:0];
        iprm_pkg::REG_DEST_ADDR:   destination_addr <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      iprm_pkg::REG_EXPECTED_ID: prdata = {16'd0, expected_id};
      iprm_pkg::REG_CURRENT_TTL: prdata = {24'd0, current_ttl};
      iprm_pkg::REG_DEST_ADDR:   prdata = destination_addr;
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg.expected_id      = expected_id;
  assign cfg.current_ttl      = current_ttl;
  assign cfg.destination_addr = destination_addr;

endmodule

// File: rtl/iprm_parser.sv
// Byte-wise packet parser: header offsets, ICMP kind, id, seq and source.
module iprm_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output iprm_pkg::summary_t  summary
);

  logic [15:0]     byte_position;
  logic [5:0]      icmp_offset;
  logic [7:0]      echo_offset;
  iprm_pkg::kind_t kind_seen;
  logic [15:0]     id_acc;
  logic [15:0]     seq_acc;
  logic [31:0]     src_acc;
  logic            fields_complete;

  logic [15:0]     byte_position_next;
  logic [5:0]      icmp_offset_next;
  logic [7:0]      echo_offset_next;
  iprm_pkg::kind_t kind_seen_next;
  logic [15:0]     id_acc_next;
  logic [15:0]     seq_acc_next;
  logic [31:0]     src_acc_next;
  logic            fields_complete_next;

  logic [15:0] pos_max;
  logic [15:0] icmp_pos;
  logic [15:0] echo_pos;
  logic [5:0]  nibble_x4;
  logic        parse;
  logic        good;

  assign pos_max   = MAX_PACKET_BYTES[15:0];
  assign nibble_x4 = {data_byte[3:0], 2'b00};
  assign parse     = byte_position < pos_max;

  // Single pass over one byte; later checks see updates of earlier ones
  always_comb begin
    icmp_offset_next     = icmp_offset;
    echo_offset_next     = echo_offset;
    kind_seen_next       = kind_seen;
    id_acc_next          = id_acc;
    seq_acc_next         = seq_acc;
    src_acc_next         = src_acc;
    fields_complete_next = fields_complete;
    byte_position_next   = byte_position;
    icmp_pos             = 16'd0;
    echo_pos             = 16'd0;
    if (parse) begin
      byte_position_next = byte_position + 16'd1;
      if (byte_position == 16'd0) begin
        icmp_offset_next = nibble_x4;
      end
      icmp_pos = {10'd0, icmp_offset_next};
      if (byte_position == icmp_pos && kind_seen == iprm_pkg::KIND_NONE) begin
        if (data_byte == iprm_pkg::ICMP_ECHO_REPLY) begin
          kind_seen_next   = iprm_pkg::KIND_ECHO;
          echo_offset_next = {2'b00, icmp_offset_next};
        end else if (data_byte == iprm_pkg::ICMP_TTL_EXCEEDED) begin
          kind_seen_next = iprm_pkg::KIND_TE_WAIT;
        end
      end
      if (kind_seen_next == iprm_pkg::KIND_TE_WAIT &&
          byte_position == icmp_pos + iprm_pkg::INNER_HDR_OFFSET) begin
        echo_offset_next = byte_position[7:0] + {2'b00, nibble_x4};
        kind_seen_next   = iprm_pkg::KIND_TE_FOUND;
      end
      if (byte_position >= iprm_pkg::SRC_FIRST_BYTE &&
          byte_position <= iprm_pkg::SRC_LAST_BYTE) begin
        src_acc_next = {src_acc[23:0], data_byte};
      end
      echo_pos = {8'd0, echo_offset_next};
      if (kind_seen_next == iprm_pkg::KIND_ECHO ||
          kind_seen_next == iprm_pkg::KIND_TE_FOUND) begin
        // Fields arrive low byte first
        if (byte_position == echo_pos + 16'd4) id_acc_next[7:0]   = data_byte;
        if (byte_position == echo_pos + 16'd5) id_acc_next[15:8]  = data_byte;
        if (byte_position == echo_pos + 16'd6) seq_acc_next[7:0]  = data_byte;
        if (byte_position == echo_pos + 16'd7) begin
          seq_acc_next[15:8]   = data_byte;
          fields_complete_next = 1'b1;
        end
      end
    end
  end

  assign good = (kind_seen_next == iprm_pkg::KIND_ECHO ||
                 kind_seen_next == iprm_pkg::KIND_TE_FOUND) &&
                fields_complete_next &&
                byte_position_next >= iprm_pkg::MIN_PACKET_BYTES;

  always_comb begin
    summary.well_formed = good;
    summary.reply_kind  = good && kind_seen_next == iprm_pkg::KIND_TE_FOUND;
    summary.probe_id    = good ? id_acc_next  : 16'd0;
    summary.probe_seq   = good ? seq_acc_next : 16'd0;
    summary.source_addr = good ? src_acc_next : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_position   <= 16'd0;
      icmp_offset     <= 6'd0;
      echo_offset     <= 8'd0;
      kind_seen       <= iprm_pkg::KIND_NONE;
      id_acc          <= 16'd0;
      seq_acc         <= 16'd0;
      src_acc         <= 32'd0;
      fields_complete <= 1'b0;
    end else if (accept) begin
      byte_position   <= byte_position_next;
      icmp_offset     <= icmp_offset_next;
      echo_offset     <= echo_offset_next;
      kind_seen       <= kind_seen_next;
      id_acc          <= id_acc_next;
      seq_acc         <= seq_acc_next;
      src_acc         <= src_acc_next;
      fields_complete <= fields_complete_next;
    end
  end

endmodule

// File: rtl/iprm_result.sv
// Match check against configuration and the output result register.
module iprm_result #(
  parameter int unsigned PROBES_PER_TTL = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  iprm_pkg::summary_t  summary,
  input  iprm_pkg::cfg_t      cfg,
  output logic                ready,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [71:0]         m_tdata,
  output logic [0:0]          m_tuser
);

  logic [16:0] seq_lo;
  logic [16:0] seq_hi;
  logic [16:0] seq_ext;
  logic        match;
  logic        reach;

  // seq / PROBES_PER_TTL == ttl  <=>  ttl*P <= seq < ttl*P + P
  assign seq_lo  = 17'(cfg.current_ttl * PROBES_PER_TTL);
  assign seq_hi  = seq_lo + 17'(PROBES_PER_TTL);
  assign seq_ext = {1'b0, summary.probe_seq};

  assign match = summary.well_formed && summary.probe_id == cfg.expected_id &&
                 seq_ext >= seq_lo && seq_ext < seq_hi;
  assign reach = match && summary.source_addr == cfg.destination_addr;

  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {5'd0, reach, match, summary.source_addr, summary.probe_seq,
                  summary.probe_id, summary.well_formed};
      m_tuser <= summary.reply_kind;
    end
  end

endmodule

// File: rtl/icmp_probe_reply_matcher_top.sv
// Top level of the ICMP probe reply matcher.
//
//  channel  dir  handshake                 payload
//  s_*      in   s_tvalid / s_tready       s_tdata[7:0] data_byte, s_tlast last_byte
//  m_*      out  m_tvalid / m_tready       m_tdata result fields, m_tuser reply_kind
//  apb      in   psel, penable, pready     paddr[3:2] register, pwdata / prdata
//
// One byte per cycle while s_tready is high; bytes within MAX_PACKET_BYTES
// are parsed when accepted; the result is on m_* in the cycle after the last beat.
// s_tready drops only while a result sits in the output register unread.
// Synchronous reset clears all packet state and control; registers take
// their reset values (expected_id 0, current_ttl 1, destination_addr 0).
module icmp_probe_reply_matcher_top #(
  parameter int unsigned MAX_PACKET_BYTES = 65535,
  parameter int unsigned PROBES_PER_TTL   = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] well_formed, [16:1] probe_id, [32:17] probe_seq, [64:33] source_addr,
  // [65] matched, [66] reached_dest, [71:67] zero
  output logic [71:0] m_tdata,
  output logic [0:0]  m_tuser,   // [0] reply_kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  iprm_pkg::cfg_t     cfg;
  iprm_pkg::summary_t summary;
  logic               accept;

  assign accept = s_tvalid && s_tready;

  iprm_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  iprm_parser #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .summary   (summary)
  );

  iprm_result #(
    .PROBES_PER_TTL (PROBES_PER_TTL)
  ) u_result (
    .clk      (clk),
    .rst      (rst),
    .fire     (accept && s_tlast),
    .summary  (summary),
    .cfg      (cfg),
    .ready    (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
